// ----- rtl/tnc_pkg.sv -----
// ----------------------------------------------------------------------------
// tnc_pkg
// Shared constants for the triangle normal and centroid pipeline.
// ----------------------------------------------------------------------------
package tnc_pkg;

  // Q1.14 normal format
  localparam int NormFrac = 14;
  localparam int NormBits = 16;
  // quotient bits of the normalize divide, enough for 16384
  localparam int QuotBits = 15;

  // x / 3 == (x * 43691) >> 17, exact for x below 2**16
  localparam int          Div3Shift = 17;
  localparam logic [16:0] Div3Mul   = 17'd43691;

endpackage

// ----- rtl/tnc_if.sv -----
// ----------------------------------------------------------------------------
// tnc_in_if / tnc_out_if
// Valid/ready channels carrying one triangle and one face result.
// ----------------------------------------------------------------------------
interface tnc_in_if #(
  parameter int COORD_BITS = 12
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] v0_x, v0_y, v0_z;
  logic signed [COORD_BITS-1:0] v1_x, v1_y, v1_z;
  logic signed [COORD_BITS-1:0] v2_x, v2_y, v2_z;

  modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                  v2_x, v2_y, v2_z, input ready);
  modport sink   (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                  v2_x, v2_y, v2_z, output ready);
endinterface

interface tnc_out_if #(
  parameter int COORD_BITS = 12
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] center_x, center_y, center_z;
  logic signed [15:0]           normal_x, normal_y, normal_z;
  logic                         degenerate;

  modport source (output valid, center_x, center_y, center_z, normal_x, normal_y,
                  normal_z, degenerate, input ready);
  modport sink   (input valid, center_x, center_y, center_z, normal_x, normal_y,
                  normal_z, degenerate, output ready);
endinterface

// ----- rtl/triangle_normal_centroid.sv -----
// ----------------------------------------------------------------------------
// triangle_normal_centroid
// Unit face normal (Q1.14) and centroid of one triangle per beat.
// ----------------------------------------------------------------------------
// in_i carries three vertices (signed, 4 fraction bits). out_o returns the
// centroid (sum / 3, truncated toward zero), the unit normal of
// (v0 - v2) x (v1 - v2) in Q1.14 and a degenerate flag; a zero cross
// product gives a zero normal with degenerate set.
// Throughput: one triangle per cycle while out_o is not stalled. Stages:
// 6 front stages, 2*COORD_BITS+2 square-root stages (one root bit
// each), 15 divide stages (one quotient bit each) and the output register.
// The whole pipeline moves on one enable: when out_o is stalled with a
// result held, every stage holds and in_i.ready drops; bubbles are kept.
// Reset clears all valid bits; no result is pending after reset.
// ----------------------------------------------------------------------------
module triangle_normal_centroid #(
  parameter int COORD_BITS = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tnc_in_if.sink    in_i,
  tnc_out_if.source out_o
);

  localparam int N    = COORD_BITS;
  localparam int DW   = N + 1;          // vertex difference
  localparam int SMW  = N + 2;          // coordinate sum
  localparam int PW   = 2 * DW;         // product
  localparam int CW   = PW + 1;         // cross component
  localparam int MW   = CW - 1;         // cross magnitude
  localparam int SW   = 2 * MW;         // squared length
  localparam int RW   = SW / 2;         // root
  localparam int QB   = tnc_pkg::QuotBits;
  localparam int NF   = tnc_pkg::NormFrac;
  localparam int NB   = tnc_pkg::NormBits;
  localparam int DRW  = MW + NF;        // divide remainder
  localparam int D3S  = tnc_pkg::Div3Shift;

  typedef struct packed {
    logic [2:0][MW-1:0] mag;
    logic [2:0]         neg;
    logic               degen;
    logic [2:0][N-1:0]  cen;
  } side_t;

  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // ---- stage 1: differences and sums
  logic                  v1_q;
  logic signed [DW-1:0]  a_q [3];
  logic signed [DW-1:0]  b_q [3];
  logic signed [SMW-1:0] sum_q [3];
  logic signed [N-1:0]   vin [3][3];

  assign vin[0][0] = in_i.v0_x;  assign vin[0][1] = in_i.v0_y;  assign vin[0][2] = in_i.v0_z;
  assign vin[1][0] = in_i.v1_x;  assign vin[1][1] = in_i.v1_y;  assign vin[1][2] = in_i.v1_z;
  assign vin[2][0] = in_i.v2_x;  assign vin[2][1] = in_i.v2_y;  assign vin[2][2] = in_i.v2_z;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a_q[k]   <= DW'(vin[0][k]) - DW'(vin[2][k]);
        b_q[k]   <= DW'(vin[1][k]) - DW'(vin[2][k]);
        sum_q[k] <= SMW'(vin[0][k]) + SMW'(vin[1][k]) + SMW'(vin[2][k]);
      end
    end
  end

  // ---- stage 2: cross products, centroid divide
  logic                 v2_q;
  logic signed [PW-1:0] p_q [6];
  logic [2:0][N-1:0]    cen2_q;
  logic [2:0][N-1:0]    cen2_d;

  always_comb begin
    logic [SMW-1:0]     m;
    logic [SMW+16:0]    prod;
    logic [N-1:0]       q;
    for (int k = 0; k < 3; k++) begin
      m         = sum_q[k][SMW-1] ? SMW'(-sum_q[k]) : SMW'(sum_q[k]);
      prod      = (SMW+17)'(m) * (SMW+17)'(tnc_pkg::Div3Mul);
      q         = N'(prod >> D3S);
      cen2_d[k] = sum_q[k][SMW-1] ? N'(-q) : q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= PW'(a_q[1]) * PW'(b_q[2]);
      p_q[1] <= PW'(a_q[2]) * PW'(b_q[1]);
      p_q[2] <= PW'(a_q[2]) * PW'(b_q[0]);
      p_q[3] <= PW'(a_q[0]) * PW'(b_q[2]);
      p_q[4] <= PW'(a_q[0]) * PW'(b_q[1]);
      p_q[5] <= PW'(a_q[1]) * PW'(b_q[0]);
      cen2_q <= cen2_d;
    end
  end

  // ---- stage 3: cross components
  logic                 v3_q;
  logic signed [CW-1:0] c_q [3];
  logic [2:0][N-1:0]    cen3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        c_q[k] <= CW'(p_q[2*k]) - CW'(p_q[2*k+1]);
      end
      cen3_q <= cen2_q;
    end
  end

  // ---- stage 4: magnitudes and signs
  logic  v4_q;
  side_t side4_q;
  side_t side4_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      side4_d.neg[k] = c_q[k][CW-1];
      side4_d.mag[k] = c_q[k][CW-1] ? MW'(-c_q[k]) : MW'(c_q[k]);
    end
    side4_d.degen = (c_q[0] == '0) && (c_q[1] == '0) && (c_q[2] == '0);
    side4_d.cen   = cen3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) side4_q <= side4_d;
  end

  // ---- stage 5: squares
  logic          v5_q;
  side_t         side5_q;
  logic [SW-1:0] sq_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= SW'(side4_q.mag[k]) * SW'(side4_q.mag[k]);
      end
      side5_q <= side4_q;
    end
  end

  // ---- stage 6: squared length
  logic          v6_q;
  side_t         side6_q;
  logic [SW-1:0] len2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      len2_q  <= sq_q[0] + sq_q[1] + sq_q[2];
      side6_q <= side5_q;
    end
  end

  // ---- square root, one root bit per stage
  logic [RW:0]   sv_q;
  logic [SW-1:0] rad_q  [RW+1];
  logic [RW:0]   rem_q  [RW+1];
  logic [RW-1:0] root_q [RW+1];
  side_t         sside_q [RW+1];

  assign sv_q[0]    = v6_q;
  assign rad_q[0]   = len2_q;
  assign rem_q[0]   = '0;
  assign root_q[0]  = '0;
  assign sside_q[0] = side6_q;

  for (genvar s = 0; s < RW; s++) begin : g_sqrt
    logic [RW+2:0] rem_sh;
    logic [RW+2:0] trial;
    logic          take;
    logic          sv_r;
    logic [SW-1:0] rad_r;
    logic [RW:0]   rem_r;
    logic [RW-1:0] root_r;
    side_t         side_r;

    assign rem_sh = {rem_q[s], rad_q[s][SW-1 -: 2]};
    assign trial  = {1'b0, root_q[s], 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_r <= 1'b0;
      end else if (en) begin
        sv_r <= sv_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rad_r  <= rad_q[s] << 2;
        rem_r  <= take ? (RW+1)'(rem_sh - trial) : (RW+1)'(rem_sh);
        root_r <= {root_q[s][RW-2:0], take};
        side_r <= sside_q[s];
      end
    end

    assign sv_q[s+1]    = sv_r;
    assign rad_q[s+1]   = rad_r;
    assign rem_q[s+1]   = rem_r;
    assign root_q[s+1]  = root_r;
    assign sside_q[s+1] = side_r;
  end

  // ---- normalize divide, one quotient bit per stage, three lanes
  logic [QB:0]         dv_q;
  logic [2:0][DRW-1:0] drem_q [QB+1];
  logic [2:0][QB-1:0]  quot_q [QB+1];
  logic [RW-1:0]       len_q  [QB+1];
  side_t               dside_q [QB+1];

  assign dv_q[0]    = sv_q[RW];
  assign len_q[0]   = root_q[RW];
  assign quot_q[0]  = '0;
  assign dside_q[0] = sside_q[RW];

  for (genvar k = 0; k < 3; k++) begin : g_drem0
    assign drem_q[0][k] = {sside_q[RW].mag[k], {NF{1'b0}}};
  end

  for (genvar s = 0; s < QB; s++) begin : g_div
    localparam int J = QB - 1 - s;
    logic [DRW-1:0]      dsub;
    logic [2:0]          take;
    logic                dv_r;
    logic [2:0][DRW-1:0] drem_r;
    logic [2:0][QB-1:0]  quot_r;
    logic [RW-1:0]       len_r;
    side_t               side_r;

    assign dsub = DRW'(len_q[s]) << J;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_r <= 1'b0;
      end else if (en) begin
        dv_r <= dv_q[s];
      end
    end

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        take[k] = drem_q[s][k] >= dsub;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          drem_r[k] <= take[k] ? drem_q[s][k] - dsub : drem_q[s][k];
          quot_r[k] <= {quot_q[s][k][QB-2:0], take[k]};
        end
        len_r  <= len_q[s];
        side_r <= dside_q[s];
      end
    end

    assign dv_q[s+1]    = dv_r;
    assign drem_q[s+1]  = drem_r;
    assign quot_q[s+1]  = quot_r;
    assign len_q[s+1]   = len_r;
    assign dside_q[s+1] = side_r;
  end

  // ---- output register
  logic [2:0][NB-1:0] norm_d;
  logic [2:0][NB-1:0] norm_q;
  logic [2:0][N-1:0]  cen_q;
  logic               degen_q;

  always_comb begin
    logic [NB-1:0] qe;
    for (int k = 0; k < 3; k++) begin
      qe        = NB'(quot_q[QB][k]);
      norm_d[k] = dside_q[QB].degen ? '0 : (dside_q[QB].neg[k] ? NB'(-qe) : qe);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      norm_q  <= norm_d;
      cen_q   <= dside_q[QB].cen;
      degen_q <= dside_q[QB].degen;
    end
  end

  // front valid chain and output valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_i.valid;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= v5_q;
      out_valid_q <= dv_q[QB];
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.center_x   = cen_q[0];
  assign out_o.center_y   = cen_q[1];
  assign out_o.center_z   = cen_q[2];
  assign out_o.normal_x   = norm_q[0];
  assign out_o.normal_y   = norm_q[1];
  assign out_o.normal_z   = norm_q[2];
  assign out_o.degenerate = degen_q;

  // ---- assertions
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && degen_q |-> (norm_q[0] == '0) && (norm_q[1] == '0) && (norm_q[2] == '0))
    else $error("degenerate face with nonzero normal");

  a_nondegen_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !degen_q |-> (norm_q[0] != '0) || (norm_q[1] != '0) || (norm_q[2] != '0))
    else $error("zero normal on a face with area");

  a_root_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q[RW] && !sside_q[RW].degen |-> root_q[RW] != '0)
    else $error("zero root for nonzero cross product");

  // zero divisor on degenerate faces saturates the quotient; it is masked later
  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[QB] && !dside_q[QB].degen |->
      (quot_q[QB][0] <= QB'(16384)) && (quot_q[QB][1] <= QB'(16384))
      && (quot_q[QB][2] <= QB'(16384)))
    else $error("normal component above one");

endmodule

// ----- verif/tnc_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tnc_checker
// Watches both channels, predicts each face result and compares in order.
// ----------------------------------------------------------------------------
module tnc_checker #(
  parameter int COORD_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tnc_in_if.sink      in_i,
  tnc_out_if.sink     out_i,
  output int          fail_cnt_o,
  output int          pending_o
);

  typedef struct packed {
    logic [COORD_BITS-1:0] cx, cy, cz;
    logic [15:0]           nx, ny, nz;
    logic                  degen;
  } face_t;

  face_t face_q[$];

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      b = r | (64'd1 << i);
      if (b * b <= n) r = b;
    end
    return r;
  endfunction

  function automatic longint third_trunc(longint s);
    return (s < 0) ? -((-s) / 3) : s / 3;
  endfunction

  function automatic logic [15:0] unit_comp(longint c, longint unsigned len);
    longint unsigned mag;
    longint unsigned q;
    mag = (c < 0) ? -c : c;
    q = (mag * 16384) / len;
    return (c < 0) ? 16'(-q) : 16'(q);
  endfunction

  function automatic face_t face_of(longint p[3][3]);
    face_t f;
    longint a[3], b[3], c[3];
    longint unsigned sq, len;
    logic [COORD_BITS-1:0] cen[3];
    for (int k = 0; k < 3; k++) begin
      cen[k] = COORD_BITS'(third_trunc(p[0][k] + p[1][k] + p[2][k]));
      a[k] = p[0][k] - p[2][k];
      b[k] = p[1][k] - p[2][k];
    end
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
    f.cx = cen[0];
    f.cy = cen[1];
    f.cz = cen[2];
    if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
      f.nx = '0;
      f.ny = '0;
      f.nz = '0;
      f.degen = 1'b1;
    end else begin
      sq = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
      len = root_floor(sq);
      f.nx = unit_comp(c[0], len);
      f.ny = unit_comp(c[1], len);
      f.nz = unit_comp(c[2], len);
      f.degen = 1'b0;
    end
    return f;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    longint p[3][3];
    face_t want, got;
    if (!rst_ni) begin
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        p[0][0] = in_i.v0_x; p[0][1] = in_i.v0_y; p[0][2] = in_i.v0_z;
        p[1][0] = in_i.v1_x; p[1][1] = in_i.v1_y; p[1][2] = in_i.v1_z;
        p[2][0] = in_i.v2_x; p[2][1] = in_i.v2_y; p[2][2] = in_i.v2_z;
        face_q.insert(face_q.size(), face_of(p));
      end
      if (out_i.valid && out_i.ready) begin
        got = '{out_i.center_x, out_i.center_y, out_i.center_z, out_i.normal_x,
                out_i.normal_y, out_i.normal_z, out_i.degenerate};
        if (face_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          want = face_q.pop_front();
          if (want != got) begin
            $display("%0t: mismatch expected c=%0d,%0d,%0d n=%0d,%0d,%0d d=%0b",
                     $time, $signed(want.cx), $signed(want.cy), $signed(want.cz),
                     $signed(want.nx), $signed(want.ny), $signed(want.nz),
                     want.degen);
            $display("%0t:          actual   c=%0d,%0d,%0d n=%0d,%0d,%0d d=%0b",
                     $time, $signed(got.cx), $signed(got.cy), $signed(got.cz),
                     $signed(got.nx), $signed(got.ny), $signed(got.nz),
                     got.degen);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
      pending_o <= face_q.size();
    end
  end

endmodule

// ----- verif/triangle_normal_centroid_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_normal_centroid_tb
// Directed corner triangles then random ones, with random stalls both sides.
// ----------------------------------------------------------------------------
module triangle_normal_centroid_tb;

  localparam int CB       = 12;
  localparam int N_RAND   = 2000;
  localparam int DRAIN    = 100;
  localparam int MAX_CYC  = 400000;
  localparam logic signed [CB-1:0] CMAX = 2047;
  localparam logic signed [CB-1:0] CMIN = -2048;

  logic clk_i;
  logic rst_ni;
  int   fail_cnt;
  int   pending;
  int   cyc;
  bit   stim_done;

  tnc_in_if  #(.COORD_BITS(CB)) in_ch ();
  tnc_out_if #(.COORD_BITS(CB)) out_ch ();

  triangle_normal_centroid #(.COORD_BITS(CB)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  tnc_checker #(.COORD_BITS(CB)) u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_i(out_ch.sink),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cyc = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc > MAX_CYC) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // result side: random stall per beat, with quiet stretches
  initial begin
    int w;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk_i);
    end
  end

  task automatic send_tri(input logic signed [CB-1:0] v[9], input bit burst);
    int w;
    w = burst ? 0 : $urandom_range(0, 8);
    if (w > 0) begin
      in_ch.valid <= 1'b0;
      repeat (w) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    {in_ch.v0_x, in_ch.v0_y, in_ch.v0_z} <= {v[0], v[1], v[2]};
    {in_ch.v1_x, in_ch.v1_y, in_ch.v1_z} <= {v[3], v[4], v[5]};
    {in_ch.v2_x, in_ch.v2_y, in_ch.v2_z} <= {v[6], v[7], v[8]};
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  function automatic logic signed [CB-1:0] rnd_coord(int mode);
    case (mode)
      0: return CB'($urandom_range(0, 4095));
      1: return $urandom_range(0, 1) ? CMAX : CMIN;
      default: return CB'(int'($urandom_range(0, 64)) - 32);
    endcase
  endfunction

  initial begin
    logic signed [CB-1:0] v[9];
    bit burst;
    int mode;
    stim_done = 0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    {in_ch.v0_x, in_ch.v0_y, in_ch.v0_z} = '0;
    {in_ch.v1_x, in_ch.v1_y, in_ch.v1_z} = '0;
    {in_ch.v2_x, in_ch.v2_y, in_ch.v2_z} = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: degenerate shapes, extremes, axis normals
    v = '{default: 0};                               send_tri(v, 0);
    v = '{default: CMAX};                            send_tri(v, 0);
    v = '{default: CMIN};                            send_tri(v, 1);
    v = '{16, 16, 16, 32, 32, 32, 48, 48, 48};       send_tri(v, 1); // collinear
    v = '{16, 0, 0, 0, 16, 0, 0, 0, 0};              send_tri(v, 1); // +z
    v = '{0, 16, 0, 16, 0, 0, 0, 0, 0};              send_tri(v, 0); // -z
    v = '{0, 16, 0, 0, 0, 16, 0, 0, 0};              send_tri(v, 1); // +x
    v = '{0, 0, 16, 16, 0, 0, 0, 0, 0};              send_tri(v, 1); // +y
    v = '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN}; send_tri(v, 0);
    v = '{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX}; send_tri(v, 1);
    v = '{CMAX, CMAX, 0, CMIN, CMAX, 0, CMAX, CMIN, 0};          send_tri(v, 1);
    v = '{-1, -1, -1, -2, 1, 0, 1, -2, 0};           send_tri(v, 0); // neg sums
    v = '{-5, 7, -11, 3, -2, 9, -1, 4, -6};          send_tri(v, 1);
    v = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                send_tri(v, 1);

    for (int n = 0; n < N_RAND; n++) begin
      mode = $urandom_range(0, 9);
      burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 9; k++)
        v[k] = rnd_coord(mode < 6 ? 0 : (mode < 7 ? 1 : 2));
      if (mode == 9) begin
        // make some degenerate: repeat a vertex
        for (int k = 0; k < 3; k++) v[3 + k] = v[$urandom_range(0, 1) * 6 + k];
      end
      send_tri(v, burst);
    end
    in_ch.valid <= 1'b0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
